[sv/world_to_screen_projection_top_defines.svh]
// ----------------------------------------------------------------------------
// world to screen projection assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_TOP_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define WSP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("wsp assertion failed");
`define WSP_ASSERT_NEVER(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("wsp forbidden condition seen");
`else
`define WSP_ASSERT(label, prop)
`define WSP_ASSERT_NEVER(label, prop)
`endif

`endif

[sv/wsp_pkg.sv]
// ----------------------------------------------------------------------------
// wsp_pkg
// shared constants and types of the world to screen projection pipeline
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned QW        = 32 + FRAC_BITS;  // quotient width
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned SIZE_W    = 13;

  localparam logic [IDX_W-1:0] REG_COL_X_FIRST  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_COL_X_SECOND = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_COL_Y_FIRST  = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_COL_Y_SECOND = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_COL_W_FIRST  = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_COL_W_SECOND = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_SCREEN_W     = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_SCREEN_H     = IDX_W'(7);

  localparam logic [63:0] ONE_HI = 64'(1) << (32 + FRAC_BITS);

  // sideband that travels beside the divider
  typedef struct packed {
    logic               valid;
    logic               neg_x;
    logic               neg_y;
    logic               w_zero;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } wsp_side_t;

endpackage

[sv/wsp_if.sv]
// ----------------------------------------------------------------------------
// wsp channel interfaces
// point request, screen result and register write channels
// ----------------------------------------------------------------------------
interface wsp_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] world_z;
  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

interface wsp_screen_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic               w_was_zero;
  modport source (output valid, screen_x, screen_y, w_was_zero, input ready);
  modport sink   (input valid, screen_x, screen_y, w_was_zero, output ready);
endinterface

interface wsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/world_to_screen_projection_top.sv]
// throughput: one point per cycle while the result is taken; the 48-stage divider chain sets the depth
// the whole pipeline advances together and holds while the result is not taken
// reset: matrix returns to identity-like defaults, viewport to 1280 x 720,
//   all stage valid bits clear
// ----------------------------------------------------------------------------
// world_to_screen_projection_top
// matrix multiply, perspective divide and viewport mapping in one pipeline
// ----------------------------------------------------------------------------
`include "world_to_screen_projection_top_defines.svh"

module world_to_screen_projection_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  wsp_point_if.sink  in_i,
  wsp_screen_if.source out_o,
  wsp_cfg_if.sink    cfg_i
);
  import wsp_pkg::*;

  localparam int unsigned NW = QW + 2;           // mapped operand width
  localparam int unsigned TW = NW + SIZE_W + 1;  // product width

  // configuration
  logic [63:0]       colx_a_q, colx_b_q, coly_a_q, coly_b_q, colw_a_q, colw_b_q;
  logic [SIZE_W-1:0] scr_w_q, scr_h_q;
  logic              cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colx_a_q <= 64'd65536;
      colx_b_q <= '0;
      coly_a_q <= ONE_HI;
      coly_b_q <= '0;
      colw_a_q <= '0;
      colw_b_q <= ONE_HI;
      scr_w_q  <= SIZE_W'(1280);
      scr_h_q  <= SIZE_W'(720);
    end else if (cfg_we) begin
      unique case (cfg_i.index)
        REG_COL_X_FIRST:  colx_a_q <= cfg_i.data;
        REG_COL_X_SECOND: colx_b_q <= cfg_i.data;
        REG_COL_Y_FIRST:  coly_a_q <= cfg_i.data;
        REG_COL_Y_SECOND: coly_b_q <= cfg_i.data;
        REG_COL_W_FIRST:  colw_a_q <= cfg_i.data;
        REG_COL_W_SECOND: colw_b_q <= cfg_i.data;
        REG_SCREEN_W:     scr_w_q  <= cfg_i.data[SIZE_W-1:0];
        REG_SCREEN_H:     scr_h_q  <= cfg_i.data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // matrix entries, [column][row]
  logic signed [31:0] m [0:2][0:3];
  always_comb begin
    m[0][0] = colx_a_q[31:0]; m[0][1] = colx_a_q[63:32];
    m[0][2] = colx_b_q[31:0]; m[0][3] = colx_b_q[63:32];
    m[1][0] = coly_a_q[31:0]; m[1][1] = coly_a_q[63:32];
    m[1][2] = coly_b_q[31:0]; m[1][3] = coly_b_q[63:32];
    m[2][0] = colw_a_q[31:0]; m[2][1] = colw_a_q[63:32];
    m[2][2] = colw_b_q[31:0]; m[2][3] = colw_b_q[63:32];
  end

  // global advance
  logic en;
  logic out_v_q;
  assign en       = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  // stage 0: input capture
  logic               v0_q;
  logic signed [31:0] pt_q [0:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= in_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q[0] <= in_i.world_x;
      pt_q[1] <= in_i.world_y;
      pt_q[2] <= in_i.world_z;
    end
  end

  // stage 1: nine products
  logic               v1_q;
  logic signed [63:0] prod_q [0:2][0:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= v0_q;
  end

  for (genvar c = 0; c < 3; c++) begin : g_col
    for (genvar r = 0; r < 3; r++) begin : g_row
      always_ff @(posedge clk_i) begin
        if (en) prod_q[c][r] <= pt_q[r] * m[c][r];
      end
    end
  end

  // stage 2: floor shifted sums, saturated clip values
  logic               v2_q;
  logic signed [31:0] clip_q [0:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  for (genvar c = 0; c < 3; c++) begin : g_sum
    logic signed [65:0] acc;
    logic signed [31:0] sat;
    always_comb begin
      acc = 66'(prod_q[c][0] >>> FRAC_BITS) + 66'(prod_q[c][1] >>> FRAC_BITS)
          + 66'(prod_q[c][2] >>> FRAC_BITS) + 66'(m[c][3]);
      if (acc > 66'sh7FFFFFFF)       sat = 32'sh7FFFFFFF;
      else if (acc < -66'sh80000000) sat = 32'sh80000000;
      else                           sat = acc[31:0];
    end
    always_ff @(posedge clk_i) begin
      if (en) clip_q[c] <= sat;
    end
  end

  // stage 3: magnitudes into the divider
  logic [31:0]   ax, ay, aw;
  logic [QW-1:0] num_x, num_y;
  wsp_side_t     side_in, side_out;
  logic [QW-1:0] quo_x, quo_y;

  always_comb begin
    ax = clip_q[0][31] ? 32'(-clip_q[0]) : clip_q[0];
    ay = clip_q[1][31] ? 32'(-clip_q[1]) : clip_q[1];
    aw = clip_q[2][31] ? 32'(-clip_q[2]) : clip_q[2];
    num_x = {ax, {FRAC_BITS{1'b0}}};
    num_y = {ay, {FRAC_BITS{1'b0}}};
    side_in.valid  = v2_q;
    side_in.neg_x  = clip_q[0][31] ^ clip_q[2][31];
    side_in.neg_y  = clip_q[1][31] ^ clip_q[2][31];
    side_in.w_zero = clip_q[2] == '0;
    side_in.cx     = clip_q[0];
    side_in.cy     = clip_q[1];
  end

  wsp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .num_x_i (num_x),
    .num_y_i (num_y),
    .den_i   (aw),
    .side_i  (side_in),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y),
    .side_o  (side_out)
  );

  // stage 4: signed normalized value plus one, y flipped
  logic                 v4_q, wz4_q;
  logic signed [NW-1:0] ox_q, oy_q;
  logic signed [NW-1:0] qx_s, qy_s, nx, ny;
  logic signed [NW-1:0] one;

  always_comb begin
    one  = NW'(1) << FRAC_BITS;
    qx_s = $signed({2'b00, quo_x});
    qy_s = $signed({2'b00, quo_y});
    if (side_out.w_zero) begin
      nx = NW'(side_out.cx);
      ny = -NW'(side_out.cy);
    end else begin
      nx = side_out.neg_x ? -qx_s : qx_s;
      ny = side_out.neg_y ? qy_s : -qy_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= side_out.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q  <= nx + one;
      oy_q  <= ny + one;
      wz4_q <= side_out.w_zero;
    end
  end

  // stage 5: scale by viewport size
  logic                 v5_q, wz5_q;
  logic signed [TW-1:0] tx_q, ty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx_q  <= TW'(ox_q) * TW'($signed({1'b0, scr_w_q}));
      ty_q  <= TW'(oy_q) * TW'($signed({1'b0, scr_h_q}));
      wz5_q <= wz4_q;
    end
  end

  // stage 6: halve and saturate into the output register
  logic signed [TW-1:0] hx, hy;
  logic signed [31:0]   sx, sy;
  logic signed [31:0]   sx_q, sy_q;
  logic                 wz_q;

  always_comb begin
    hx = tx_q >>> 1;
    hy = ty_q >>> 1;
    if (hx > TW'(32'sh7FFFFFFF))       sx = 32'sh7FFFFFFF;
    else if (hx < -(TW'(1) <<< 31))    sx = 32'sh80000000;
    else                               sx = hx[31:0];
    if (hy > TW'(32'sh7FFFFFFF))       sy = 32'sh7FFFFFFF;
    else if (hy < -(TW'(1) <<< 31))    sy = 32'sh80000000;
    else                               sy = hy[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q <= sx;
      sy_q <= sy;
      wz_q <= wz5_q;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.screen_x   = sx_q;
  assign out_o.screen_y   = sy_q;
  assign out_o.w_was_zero = wz_q;

  // checks
  logic [5:0]        vld_vec;
  logic              scr_w_wr;
  logic [SIZE_W-1:0] cfg_size;
  assign vld_vec  = {v0_q, v1_q, v2_q, v4_q, v5_q, out_v_q};
  assign scr_w_wr = cfg_we && (cfg_i.index == REG_SCREEN_W);
  assign cfg_size = cfg_i.data[SIZE_W-1:0];

  `WSP_ASSERT(a_stall_holds_valids, !en |=> $stable(vld_vec))
  `WSP_ASSERT(a_request_enters, (in_i.valid && in_i.ready) |=> v0_q)
  `WSP_ASSERT(a_width_write_lost, scr_w_wr |=> scr_w_q == $past(cfg_size))
  `WSP_ASSERT_NEVER(a_out_valid_unknown, $isunknown(out_o.valid))

endmodule

[sv/wsp_div.sv]
// ----------------------------------------------------------------------------
// wsp_div
// pipelined restoring divider, one quotient bit per stage, two lanes
// ----------------------------------------------------------------------------
module wsp_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [wsp_pkg::QW-1:0]        num_x_i,
  input  logic [wsp_pkg::QW-1:0]        num_y_i,
  input  logic [31:0]                   den_i,
  input  wsp_pkg::wsp_side_t            side_i,
  output logic [wsp_pkg::QW-1:0]        quo_x_o,
  output logic [wsp_pkg::QW-1:0]        quo_y_o,
  output wsp_pkg::wsp_side_t            side_o
);
  import wsp_pkg::*;

  logic [31:0]    rem_x [0:QW];
  logic [31:0]    rem_y [0:QW];
  logic [QW-1:0]  nq_x  [0:QW];
  logic [QW-1:0]  nq_y  [0:QW];
  logic [31:0]    den   [0:QW];
  wsp_side_t      side  [0:QW];

  assign rem_x[0] = '0;
  assign rem_y[0] = '0;
  assign nq_x[0]  = num_x_i;
  assign nq_y[0]  = num_y_i;
  assign den[0]   = den_i;
  assign side[0]  = side_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [32:0] trial_x, trial_y;
    logic        ge_x, ge_y;
    logic [31:0] rem_x_d, rem_y_d;

    always_comb begin
      trial_x = {rem_x[k], nq_x[k][QW-1]};
      trial_y = {rem_y[k], nq_y[k][QW-1]};
      ge_x    = trial_x >= {1'b0, den[k]};
      ge_y    = trial_y >= {1'b0, den[k]};
      rem_x_d = ge_x ? 32'(trial_x - {1'b0, den[k]}) : trial_x[31:0];
      rem_y_d = ge_y ? 32'(trial_y - {1'b0, den[k]}) : trial_y[31:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side[k+1] <= '0;
      end else if (en_i) begin
        side[k+1] <= side[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_x[k+1] <= rem_x_d;
        rem_y[k+1] <= rem_y_d;
        nq_x[k+1]  <= {nq_x[k][QW-2:0], ge_x};
        nq_y[k+1]  <= {nq_y[k][QW-2:0], ge_y};
        den[k+1]   <= den[k];
      end
    end
  end

  assign quo_x_o = nq_x[QW];
  assign quo_y_o = nq_y[QW];
  assign side_o  = side[QW];

endmodule

[bench/tb_world_to_screen_projection_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// world to screen projection testbench
// drives points and register writes under random idling, predicts each
// screen result in a scoreboard and compares every field in order
// ----------------------------------------------------------------------------

class wsp_screen_scoreboard;
  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               wz;
  } screen_t;

  screen_t     pending_q[$];
  logic [63:0] matrix_regs[8];
  int          errors;

  function new();
    matrix_regs[0] = 64'd65536;
    matrix_regs[1] = '0;
    matrix_regs[2] = wsp_pkg::ONE_HI;
    matrix_regs[3] = '0;
    matrix_regs[4] = '0;
    matrix_regs[5] = wsp_pkg::ONE_HI;
    matrix_regs[6] = 64'd1280;
    matrix_regs[7] = 64'd720;
    errors = 0;
  endfunction

  function void write_reg(logic [7:0] idx, logic [63:0] val);
    if (idx > wsp_pkg::REG_SCREEN_H) return;  // out of range writes are dropped
    if (idx >= wsp_pkg::REG_SCREEN_W) matrix_regs[idx[2:0]] = {51'b0, val[12:0]};
    else matrix_regs[idx[2:0]] = val;
  endfunction

  function longint sat32(longint v);
    if (v < -64'sd2147483648) return -64'sd2147483648;
    if (v > 64'sd2147483647) return 64'sd2147483647;
    return v;
  endfunction

  function longint clamp_ndc(longint v);
    longint lim;
    lim = longint'(1) <<< 50;
    if (v < -lim) return -lim;
    if (v > lim) return lim;
    return v;
  endfunction

  function longint clip_sum(longint x, longint y, longint z, logic [63:0] f, logic [63:0] s);
    longint acc;
    acc = (x * longint'($signed(f[31:0]))) >>> wsp_pkg::FRAC_BITS;
    acc += (y * longint'($signed(f[63:32]))) >>> wsp_pkg::FRAC_BITS;
    acc += (z * longint'($signed(s[31:0]))) >>> wsp_pkg::FRAC_BITS;
    acc += longint'($signed(s[63:32]));
    return sat32(acc);
  endfunction

  function longint div_trunc(longint num, longint den);
    longint a, b, q;
    a = num < 0 ? -num : num;
    b = den < 0 ? -den : den;
    q = (a <<< wsp_pkg::FRAC_BITS) / b;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function longint to_pixels(longint n, logic [63:0] size);
    longint t;
    t = (clamp_ndc(n) + (longint'(1) <<< wsp_pkg::FRAC_BITS)) * longint'({51'b0, size[12:0]});
    return sat32(t >>> 1);
  endfunction

  function void note_point(logic signed [31:0] wx, logic signed [31:0] wy,
                           logic signed [31:0] wz_in);
    longint x, y, z, cx, cy, cw, nx, ny;
    screen_t e;
    x = wx; y = wy; z = wz_in;
    cx = clip_sum(x, y, z, matrix_regs[0], matrix_regs[1]);
    cy = clip_sum(x, y, z, matrix_regs[2], matrix_regs[3]);
    cw = clip_sum(x, y, z, matrix_regs[4], matrix_regs[5]);
    e.wz = (cw == 0);
    nx = cx;
    ny = cy;
    if (!e.wz) begin
      nx = div_trunc(cx, cw);
      ny = div_trunc(cy, cw);
    end
    e.sx = 32'(to_pixels(nx, matrix_regs[6]));
    e.sy = 32'(to_pixels(-clamp_ndc(ny), matrix_regs[7]));
    pending_q.push_back(e);
  endfunction

  function void check_screen(logic signed [31:0] sx, logic signed [31:0] sy, logic wz);
    screen_t e;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result sx=%0d sy=%0d wz=%0b", $time, sx, sy, wz);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (sx !== e.sx) begin
      $display("%0t: screen_x expected %0d actual %0d", $time, e.sx, sx);
      errors++;
    end
    if (sy !== e.sy) begin
      $display("%0t: screen_y expected %0d actual %0d", $time, e.sy, sy);
      errors++;
    end
    if (wz !== e.wz) begin
      $display("%0t: w_was_zero expected %0b actual %0b", $time, e.wz, wz);
      errors++;
    end
  endfunction
endclass

module tb_world_to_screen_projection_top;
  import wsp_pkg::*;

  localparam int LATENCY     = FRAC_BITS + 39;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [IDX_W-1:0] REG_UNUSED_A = IDX_W'(8);
  localparam logic [IDX_W-1:0] REG_UNUSED_B = IDX_W'(255);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wsp_point_if  pt();
  wsp_screen_if scr();
  wsp_cfg_if    cfg();

  world_to_screen_projection_top i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pt),
    .out_o (scr),
    .cfg_i (cfg)
  );

  wsp_screen_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  int cycles = 0;

  always #6 clk_i = ~clk_i;

  initial begin
    pt.valid = 1'b0; pt.world_x = '0; pt.world_y = '0; pt.world_z = '0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    scr.ready = 1'b0;
  end

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      scr.ready <= 1'b0;
    end else begin
      scr.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && pt.valid && pt.ready) sb.note_point(pt.world_x, pt.world_y, pt.world_z);
    if (rst_ni && scr.valid && scr.ready) sb.check_screen(scr.screen_x, scr.screen_y, scr.w_was_zero);
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      pt.valid <= 1'b0;
      @(negedge clk_i);
    end
    pt.valid   <= 1'b1;
    pt.world_x <= x;
    pt.world_y <= y;
    pt.world_z <= z;
    do @(posedge clk_i); while (!pt.ready);
  endtask

  task automatic drain();
    @(negedge clk_i);
    pt.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(2047)) - 1024);
      default: return 32'($signed($urandom_range(1 << 23)) - (1 << 22));
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(4))
      0:       return $urandom();
      1:       return '0;
      default: return 32'($signed($urandom_range(1 << 18)) - (1 << 17));
    endcase
  endfunction

  function automatic logic [63:0] rand_size();
    case ($urandom_range(5))
      0:       return 64'd0;
      1:       return 64'd1;
      2:       return 64'd4096;
      3:       return {$urandom(), $urandom()};  // upper bits ignored, 13-bit max reachable
      default: return 64'($urandom_range(4096, 1));
    endcase
  endfunction

  task automatic random_matrix();
    for (int r = 0; r < 6; r++) write_reg(IDX_W'(r), {rand_entry(), rand_entry()});
    write_reg(REG_SCREEN_W, rand_size());
    write_reg(REG_SCREEN_H, rand_size());
  endtask

  logic [31:0] corner[6] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h0001_0000};

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes under reset matrix (w is constant 1.0)
    for (int i = 0; i < 6; i++) send_point(corner[i], corner[5 - i], corner[(i + 2) % 6]);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    drain();

    // zero clip w, extreme sizes, dropped register writes
    write_reg(REG_COL_W_FIRST, 64'd0);
    write_reg(REG_COL_W_SECOND, 64'd0);
    write_reg(REG_SCREEN_W, 64'd0);
    write_reg(REG_SCREEN_H, 64'h1FFF);
    write_reg(REG_UNUSED_A, {$urandom(), $urandom()});
    write_reg(REG_UNUSED_B, {$urandom(), $urandom()});
    for (int i = 0; i < 6; i++) send_point(corner[i], corner[(i + 3) % 6], corner[i]);
    drain();

    // full-scale matrix entries force clip saturation, tiny w divides
    write_reg(REG_COL_X_FIRST, {32'h7FFF_FFFF, 32'h8000_0000});
    write_reg(REG_COL_X_SECOND, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
    write_reg(REG_COL_Y_FIRST, {32'h8000_0000, 32'h7FFF_FFFF});
    write_reg(REG_COL_Y_SECOND, {32'h8000_0000, 32'h8000_0000});
    write_reg(REG_COL_W_FIRST, 64'd0);
    write_reg(REG_COL_W_SECOND, {32'hFFFF_FFFF, 32'h0});
    write_reg(REG_SCREEN_W, 64'd4096);
    write_reg(REG_SCREEN_H, 64'd1);
    for (int i = 0; i < 6; i++) send_point(corner[i], corner[(i + 1) % 6], corner[(i + 4) % 6]);
    drain();

    // random phases: none, sender idle, receiver stall, both
    for (int p = 0; p < 8; p++) begin
      random_matrix();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      if (p == 4) hold_off = 400;  // fill the pipeline and back up the input
      for (int n = 0; n < 150; n++) send_point(rand_coord(), rand_coord(), rand_coord());
      drain();
    end

    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
